>>> rtl/core/cdsw_pkg.sv
// cdsw_pkg: shared types, operation codes and month tables for the date stepper.
// No dependencies.
`timescale 1ns / 1ps

package cdsw_pkg;

  localparam int YEAR_W     = 14;
  localparam int MONTH_W    = 4;
  localparam int DAY_W      = 5;
  localparam int WDAY_W     = 3;
  localparam int OP_W       = 2;
  localparam int SUM_W      = 15;  // day count before reduction mod 7
  localparam int REM_W      = 8;   // holds year mod 100
  localparam int CNT_W      = 3;
  localparam int CUM_W      = 9;
  localparam int OCT_W      = 3;   // 8 = 1 mod 7, so octal digits fold mod 7
  localparam int FOLD_STEPS = 5;   // brings any SUM_W count down to 0..7
  localparam int RCP_W      = 13;
  localparam int RCP_SHIFT  = 19;
  localparam int PROD_W     = YEAR_W + RCP_W;
  localparam int QUO_W      = PROD_W - RCP_SHIFT;

  localparam logic [CNT_W-1:0]  LAST_STEP     = CNT_W'(FOLD_STEPS - 1);
  localparam logic [RCP_W-1:0]  RECIP_CENTURY = RCP_W'(5243);  // 2^19 / 100, rounded up
  localparam logic [YEAR_W-1:0] CENTURY       = YEAR_W'(100);

  typedef enum logic [OP_W-1:0] {
    OP_SAME = 2'd0,
    OP_NEXT = 2'd1,
    OP_PREV = 2'd2,
    OP_RSVD = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CALC,
    ST_MOD,
    ST_DONE
  } state_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // days in the year before the first of month m, leap day added after February
  function automatic logic [CUM_W-1:0] cum_days(input logic [MONTH_W-1:0] m,
                                                input logic leap);
    logic [CUM_W-1:0] c;
    case (m)
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    if (leap && (m > 4'd2)) begin
      c = c + 9'd1;
    end
    return c;
  endfunction

endpackage

>>> rtl/core/cdsw_divstep.sv
// cdsw_divstep: one mod-7 folding step (high octal digits plus the lowest one).
// Depends on cdsw_pkg.
`timescale 1ns / 1ps

module cdsw_divstep
  import cdsw_pkg::*;
(
  input  logic [SUM_W-1:0] acc,
  output logic [SUM_W-1:0] folded
);

  assign folded = (acc >> OCT_W) + SUM_W'(acc[OCT_W-1:0]);

endmodule

>>> rtl/core/calendar_date_step_weekday_top.sv
// Gregorian date stepper with weekday: sequencer around one shared mod-7 fold step.
// Depends on cdsw_pkg and cdsw_divstep.
`timescale 1ns / 1ps

// One request at a time: in_ready is high only while the sequencer is idle.
// A request passes from acceptance to out_valid through these steps: the year
// is divided by 100 by reciprocal multiplication (leap rule and century counts),
// the date is checked and stepped and the day count formed, that count makes
// five passes through the shared mod-7 folding unit, and the output register
// is loaded. The next request can be taken the cycle after the load. The output
// register lets the next request be taken while a result still waits; a second
// result then holds the sequencer until the first is taken. Invalid dates give
// valid_res 0 and all other result fields 0.

module calendar_date_step_weekday_top
  import cdsw_pkg::*;
#(
  parameter int EPOCH_YEAR = 1970,
  parameter int LAST_YEAR  = 9999
)
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OP_W-1:0]    operation,
  input  logic [YEAR_W-1:0]  year,
  input  logic [MONTH_W-1:0] month,
  input  logic [DAY_W-1:0]   day,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [YEAR_W-1:0]  out_year,
  output logic [MONTH_W-1:0] out_month,
  output logic [DAY_W-1:0]   out_day,
  output logic [WDAY_W-1:0]  weekday,
  output logic               valid_res
);

  localparam logic [YEAR_W-1:0] YEAR_LO = YEAR_W'(EPOCH_YEAR);
  localparam logic [YEAR_W-1:0] YEAR_HI = YEAR_W'(LAST_YEAR);

  state_t state, state_next;

  logic [CNT_W-1:0]   cnt;
  logic [SUM_W-1:0]   dvd;
  logic [REM_W-1:0]   rem;
  op_t                op;
  logic [YEAR_W-1:0]  yr;
  logic [MONTH_W-1:0] mo;
  logic [DAY_W-1:0]   dy;
  logic               ok;
  logic [YEAR_W-1:0]  ny;
  logic [MONTH_W-1:0] nm;
  logic [DAY_W-1:0]   nd;

  logic               ok_next;
  logic [YEAR_W-1:0]  ny_next;
  logic [MONTH_W-1:0] nm_next;
  logic [DAY_W-1:0]   nd_next;
  logic [SUM_W-1:0]   sum_next;

  logic               step_en;
  logic               last_step;
  logic               out_load;
  logic [PROD_W-1:0]  prod;
  logic [QUO_W-1:0]   quo;
  logic [REM_W-1:0]   yrem;
  logic [SUM_W-1:0]   fold_out;

  cdsw_divstep u_divstep (
    .acc    (dvd),
    .folded (fold_out)
  );

  // year / 100 and year % 100
  assign prod = PROD_W'(yr) * PROD_W'(RECIP_CENTURY);
  assign quo  = prod[PROD_W-1:RCP_SHIFT];
  assign yrem = REM_W'(yr - YEAR_W'(quo) * CENTURY);

  assign last_step = (cnt == LAST_STEP);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_DIV;
      ST_DIV:  state_next = ST_CALC;
      ST_CALC: state_next = ST_MOD;
      ST_MOD:  if (last_step) state_next = ST_DONE;
      ST_DONE: if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready = 1'b0;
    step_en  = 1'b0;
    out_load = 1'b0;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_MOD:  step_en = 1'b1;
      ST_DONE: out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  // check, step and day count; dvd holds year/100 and rem year%100 here
  always_comb begin
    logic               cent;
    logic               leap;
    logic [YEAR_W-1:0]  p;
    logic [YEAR_W-1:0]  p100;
    logic [DAY_W-1:0]   mlen;
    logic [MONTH_W-1:0] mprev;
    cent  = (rem == '0);
    leap  = (yr[1:0] == 2'b00) && (!cent || (dvd[1:0] == 2'b00));
    p     = yr - YEAR_W'(1);
    p100  = dvd[YEAR_W-1:0] - YEAR_W'(cent);
    mlen  = month_len(mo, leap);
    mprev = mo - MONTH_W'(1);

    ok_next = (op != OP_RSVD) && (mo >= 4'd1) && (mo <= 4'd12) &&
              (yr >= YEAR_LO) && (yr <= YEAR_HI) &&
              (dy >= 5'd1) && (dy <= mlen);

    ny_next = yr;
    nm_next = mo;
    nd_next = dy;
    case (op)
      OP_NEXT: begin
        if (dy < mlen) begin
          nd_next = dy + 5'd1;
        end else begin
          nd_next = 5'd1;
          if (mo == 4'd12) begin
            nm_next = 4'd1;
            ny_next = yr + YEAR_W'(1);
          end else begin
            nm_next = mo + 4'd1;
          end
        end
      end
      OP_PREV: begin
        if (dy > 5'd1) begin
          nd_next = dy - 5'd1;
        end else if (mo == 4'd1) begin
          nm_next = 4'd12;
          ny_next = yr - YEAR_W'(1);
          nd_next = 5'd31;
        end else begin
          nm_next = mprev;
          nd_next = month_len(mprev, leap);
        end
      end
      default: ;
    endcase

    if ((ny_next < YEAR_LO) || (ny_next > YEAR_HI)) begin
      ok_next = 1'b0;
    end

    // days since 1 Jan of year 1 plus one, mod 7 taken later; 365 = 1 mod 7
    sum_next = SUM_W'(p) + SUM_W'(p >> 2) - SUM_W'(p100) + SUM_W'(p100 >> 2) +
               SUM_W'(cum_days(mo, leap)) + SUM_W'(dy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op  <= op_t'(operation);
      yr  <= year;
      mo  <= month;
      dy  <= day;
    end else if (state == ST_DIV) begin
      dvd <= SUM_W'(quo);
      rem <= yrem;
    end else if (state == ST_CALC) begin
      ok  <= ok_next;
      ny  <= ny_next;
      nm  <= nm_next;
      nd  <= nd_next;
      dvd <= sum_next;
      cnt <= '0;
    end else if (step_en) begin
      dvd <= fold_out;
      cnt <= cnt + CNT_W'(1);
    end
  end

  // after the folds dvd is 0..7, with 7 standing for 0
  always_ff @(posedge clk) begin
    logic [WDAY_W:0] wd;
    wd = {1'b0, dvd[WDAY_W-1:0]} + ((op == OP_NEXT) ? 4'd1 :
                                    (op == OP_PREV) ? 4'd6 : 4'd0);
    if (wd >= 4'd7) begin
      wd = wd - 4'd7;
    end
    if (out_load) begin
      valid_res <= ok;
      out_year  <= ok ? ny : '0;
      out_month <= ok ? nm : '0;
      out_day   <= ok ? nd : '0;
      weekday   <= ok ? wd[WDAY_W-1:0] : '0;
    end
  end

endmodule
